[design/skst_pkg.sv]
// Shared types and codes for the sorted key set table.
`default_nettype none
package skst_pkg;

   localparam int KEY_W     = 32;
   localparam int EDEPTH_W  = 8;
   localparam int POS_W     = 10;
   localparam int COUNT_W   = 11;

   typedef logic [2:0] command_type;
   typedef logic [1:0] outcome_type;

   localparam command_type CMD_INSERT = 3'd0;
   localparam command_type CMD_REMOVE = 3'd1;
   localparam command_type CMD_LOOKUP = 3'd2;
   localparam command_type CMD_READ   = 3'd3;
   localparam command_type CMD_CLEAR  = 3'd4;

   localparam outcome_type OUT_OK     = 2'd0;
   localparam outcome_type OUT_MISS   = 2'd1;
   localparam outcome_type OUT_FULL   = 2'd2;
   localparam outcome_type OUT_RANGE  = 2'd3;

   typedef struct packed {
      command_type               command;
      logic signed [KEY_W-1:0]   key;
      logic [EDEPTH_W-1:0]       entry_depth;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      outcome_type               outcome;
      logic signed [KEY_W-1:0]   out_key;
      logic [EDEPTH_W-1:0]       out_depth;
      logic [COUNT_W-1:0]        entry_count;
   } rsp_type;

endpackage
`default_nettype wire

[design/skst_ifs.sv]
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface skst_req_if;
   import skst_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface skst_rsp_if;
   import skst_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/skst_store.sv]
// Key and depth memories: one write port, one registered read port.
`default_nettype none
module skst_store #(
   parameter int CAPACITY   = 1024,
   parameter int DEPTH_BITS = 8,
   localparam int AW        = $clog2(CAPACITY)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire logic [31:0]           wr_key,
   input  wire logic [DEPTH_BITS-1:0] wr_depth,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr,
   output logic [31:0]                rd_key,
   output logic [DEPTH_BITS-1:0]      rd_depth
);
   import skst_pkg::*;

   logic [31:0]           key_mem   [CAPACITY];
   logic [DEPTH_BITS-1:0] depth_mem [CAPACITY];
   logic [31:0]           rd_key_ff;
   logic [DEPTH_BITS-1:0] rd_depth_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]   <= wr_key;
         depth_mem[wr_addr] <= wr_depth;
      end
      if (rd_en) begin
         rd_key_ff   <= key_mem[rd_addr];
         rd_depth_ff <= depth_mem[rd_addr];
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_depth = rd_depth_ff;

endmodule
`default_nettype wire

[design/skst_ctrl.sv]
// Sequencer: binary search with one shared compare, then entry-by-entry shifts.
`default_nettype none
module skst_ctrl #(
   parameter int CAPACITY   = 1024,
   parameter int DEPTH_BITS = 8,
   localparam int AW        = $clog2(CAPACITY)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire skst_pkg::req_type     req,
   input  wire logic                  slot_free,
   output logic                       done,
   output skst_pkg::rsp_type          result,
   output logic                       mem_wr_en,
   output logic [AW-1:0]              mem_wr_addr,
   output logic [31:0]                mem_wr_key,
   output logic [DEPTH_BITS-1:0]      mem_wr_depth,
   output logic                       mem_rd_en,
   output logic [AW-1:0]              mem_rd_addr,
   input  wire logic [31:0]           mem_rd_key,
   input  wire logic [DEPTH_BITS-1:0] mem_rd_depth
);
   import skst_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_PROBE  = 3'd2;
   localparam logic [2:0] ST_CHECK  = 3'd3;
   localparam logic [2:0] ST_MOVE   = 3'd4;
   localparam logic [2:0] ST_READ   = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  pend_ff, pend_in;
   command_type           cmd_ff, cmd_in;
   logic signed [31:0]    key_ff, key_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [CW-1:0]         lo_ff, lo_in;
   logic [CW-1:0]         hi_ff, hi_in;
   logic [CW-1:0]         left_ff, left_in;
   logic [AW-1:0]         rd_ff, rd_in;
   logic [AW-1:0]         pend_addr_ff, pend_addr_in;
   outcome_type           outcome_ff, outcome_in;
   logic [31:0]           out_key_ff, out_key_in;
   logic [7:0]            out_depth_ff, out_depth_in;

   logic [CW-1:0]         mid;
   logic                  resolve;
   logic                  found;

   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      depth_in     = depth_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      left_in      = left_ff;
      rd_in        = rd_ff;
      pend_addr_in = pend_addr_ff;
      outcome_in   = outcome_ff;
      out_key_in   = out_key_ff;
      out_depth_in = out_depth_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = pend_addr_ff;
      mem_wr_key   = mem_rd_key;
      mem_wr_depth = mem_rd_depth;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = mid[AW-1:0];
      done         = 1'b0;
      resolve      = 1'b0;
      found        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in       = req.command;
               key_in       = req.key;
               depth_in     = DEPTH_BITS'(req.entry_depth);
               lo_in        = '0;
               hi_in        = count_ff;
               outcome_in   = OUT_OK;
               out_key_in   = '0;
               out_depth_in = '0;
               case (req.command)
                  CMD_INSERT, CMD_REMOVE, CMD_LOOKUP: begin
                     state_in = ST_SEARCH;
                  end
                  CMD_READ: begin
                     if (32'(req.position) >= 32'(count_ff)) begin
                        outcome_in = OUT_RANGE;
                        state_in   = ST_DONE;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(req.position);
                        state_in    = ST_READ;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mid[AW-1:0];
               state_in    = ST_PROBE;
            end else if (lo_ff < count_ff) begin
               // read the candidate slot to test for equality
               mem_rd_en   = 1'b1;
               mem_rd_addr = lo_ff[AW-1:0];
               state_in    = ST_CHECK;
            end else begin
               resolve = 1'b1;
            end
         end
         ST_PROBE: begin
            if ($signed(mem_rd_key) < key_ff) begin
               lo_in = mid + CW'(1);
            end else begin
               hi_in = mid;
            end
            state_in = ST_SEARCH;
         end
         ST_CHECK: begin
            resolve = 1'b1;
            found   = (mem_rd_key == key_ff);
         end
         ST_MOVE: begin
            // write back the entry read in the previous cycle
            if (pend_ff) begin
               mem_wr_en = 1'b1;
            end
            if (left_ff != '0) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_ff;
               pend_in     = 1'b1;
               left_in     = left_ff - CW'(1);
               if (cmd_ff == CMD_INSERT) begin
                  pend_addr_in = rd_ff + AW'(1);
                  rd_in        = rd_ff - AW'(1);
               end else begin
                  pend_addr_in = rd_ff - AW'(1);
                  rd_in        = rd_ff + AW'(1);
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (cmd_ff == CMD_INSERT) begin
                     mem_wr_en    = 1'b1;
                     mem_wr_addr  = lo_ff[AW-1:0];
                     mem_wr_key   = key_ff;
                     mem_wr_depth = depth_ff;
                     count_in     = count_ff + CW'(1);
                  end else begin
                     count_in = count_ff - CW'(1);
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            out_key_in   = mem_rd_key;
            out_depth_in = 8'(mem_rd_depth);
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (resolve) begin
         state_in = ST_DONE;
         case (cmd_ff)
            CMD_INSERT: begin
               if (found) begin
                  outcome_in = OUT_MISS;
               end else if (count_ff >= CW'(CAPACITY)) begin
                  outcome_in = OUT_FULL;
               end else begin
                  left_in  = count_ff - lo_ff;
                  rd_in    = AW'(count_ff - CW'(1));
                  pend_in  = 1'b0;
                  state_in = ST_MOVE;
               end
            end
            CMD_REMOVE: begin
               if (!found) begin
                  outcome_in = OUT_MISS;
               end else begin
                  left_in  = count_ff - lo_ff - CW'(1);
                  rd_in    = AW'(lo_ff + CW'(1));
                  pend_in  = 1'b0;
                  state_in = ST_MOVE;
               end
            end
            CMD_LOOKUP: begin
               outcome_in = found ? OUT_OK : OUT_MISS;
            end
            default: begin
               outcome_in = OUT_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      depth_ff     <= depth_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      left_ff      <= left_in;
      rd_ff        <= rd_in;
      pend_addr_ff <= pend_addr_in;
      outcome_ff   <= outcome_in;
      out_key_ff   <= out_key_in;
      out_depth_ff <= out_depth_in;
   end

   assign result.outcome     = outcome_ff;
   assign result.out_key     = out_key_ff;
   assign result.out_depth   = out_depth_ff;
   assign result.entry_count = COUNT_W'(count_ff);

endmodule
`default_nettype wire

[design/sorted_key_set_table.sv]
// Top level of the sorted key set table with its response register.
`default_nettype none
// A set of distinct signed keys kept in ascending order, each with a depth
// tag, in a CAPACITY-entry memory. One request at a time: req_chan.ready is
// high only while the sequencer is idle, and each request gives one response
// that carries the count after the command. Insert, remove and lookup run a
// binary search through the single memory read port and one compare, plus
// an equality check. Insert and remove then move each higher entry one
// slot, one entry per cycle through the read and write ports. The response
// register lets the next request enter while a response waits.
module sorted_key_set_table #(
   parameter int CAPACITY   = 1024,
   parameter int DEPTH_BITS = 8
) (
   input wire logic   clock,
   input wire logic   reset,
   skst_req_if.sink   req_chan,
   skst_rsp_if.source rsp_chan
);
   import skst_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic                  done;
   logic                  slot_free;
   rsp_type               result;
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [31:0]           mem_wr_key;
   logic [DEPTH_BITS-1:0] mem_wr_depth;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   logic [31:0]           mem_rd_key;
   logic [DEPTH_BITS-1:0] mem_rd_depth;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   skst_ctrl #(
      .CAPACITY   (CAPACITY),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .req          (req_chan.payload),
      .slot_free    (slot_free),
      .done         (done),
      .result       (result),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_key   (mem_wr_key),
      .mem_wr_depth (mem_wr_depth),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_key   (mem_rd_key),
      .mem_rd_depth (mem_rd_depth)
   );

   skst_store #(
      .CAPACITY   (CAPACITY),
      .DEPTH_BITS (DEPTH_BITS)
   ) u_store (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_key   (mem_wr_key),
      .wr_depth (mem_wr_depth),
      .rd_en    (mem_rd_en),
      .rd_addr  (mem_rd_addr),
      .rd_key   (mem_rd_key),
      .rd_depth (mem_rd_depth)
   );

   // the register is free when empty or being drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the sorted key set table with its own set predictor.
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import skst_pkg::*;

   localparam int SET_CAPACITY     = 1024;
   localparam int HALF_PERIOD      = 10;
   localparam int RESET_CYCLES     = 11;
   localparam int RANDOM_ITEMS     = 580;
   localparam int CALM_ITEMS       = 100;
   localparam int PRESSURE_ITEM    = 300;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES    = 1100;
   localparam int CYCLE_LIMIT      = 6_000_000;
   localparam int REPORT_CAP       = 50;

   // Codes the block does not define; they must leave the set alone.
   localparam command_type CMD_RSVD_A = 3'd5;
   localparam command_type CMD_RSVD_B = 3'd6;
   localparam command_type CMD_RSVD_C = 3'd7;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   class key_set_board;
      logic signed [KEY_W-1:0] keys [SET_CAPACITY];
      logic [EDEPTH_W-1:0]     depths [SET_CAPACITY];
      int unsigned             held;
      int unsigned             peak;
      int unsigned             clears;
      int unsigned             checked;
      int unsigned             errors;
      int unsigned             tally [4];
      rsp_type                 pending_responses [$];

      function new();
         held = 0;
         peak = 0;
         clears = 0;
         checked = 0;
         errors = 0;
         foreach (tally[i]) tally[i] = 0;
      endfunction

      // Lowest slot whose key is not below the probe.
      function int unsigned find_slot(logic signed [KEY_W-1:0] probe, output bit present);
         int unsigned lo, hi, mid;
         lo = 0;
         hi = held;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (keys[mid] < probe) lo = mid + 1;
            else hi = mid;
         end
         present = (lo < held) && (keys[lo] == probe);
         return lo;
      endfunction

      function void note_request(req_type r);
         rsp_type     want;
         bit          present;
         int unsigned slot;
         want = '0;
         case (r.command)
            CMD_INSERT: begin
               slot = find_slot(r.key, present);
               if (present) want.outcome = OUT_MISS;
               else if (held >= SET_CAPACITY) want.outcome = OUT_FULL;
               else begin
                  for (int unsigned j = held; j > slot; j--) begin
                     keys[j] = keys[j-1];
                     depths[j] = depths[j-1];
                  end
                  keys[slot] = r.key;
                  depths[slot] = r.entry_depth;
                  held++;
               end
            end
            CMD_REMOVE: begin
               slot = find_slot(r.key, present);
               if (!present) want.outcome = OUT_MISS;
               else begin
                  for (int unsigned j = slot; j + 1 < held; j++) begin
                     keys[j] = keys[j+1];
                     depths[j] = depths[j+1];
                  end
                  held--;
               end
            end
            CMD_LOOKUP: begin
               slot = find_slot(r.key, present);
               want.outcome = present ? OUT_OK : OUT_MISS;
            end
            CMD_READ: begin
               if (r.position >= held) want.outcome = OUT_RANGE;
               else begin
                  want.out_key = keys[r.position];
                  want.out_depth = depths[r.position];
               end
            end
            CMD_CLEAR: begin
               held = 0;
               clears++;
            end
            default: ;
         endcase
         want.entry_count = COUNT_W'(held);
         if (held > peak) peak = held;
         tally[want.outcome]++;
         pending_responses.push_back(want);
      endfunction

      function void flag_mismatch(string field, logic signed [63:0] want,
                                  logic signed [63:0] got);
         errors++;
         if (errors <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_responses.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t: response with none expected: outcome %0d key %0d depth %0d count %0d",
                        $time, got.outcome, got.out_key, got.out_depth, got.entry_count);
            return;
         end
         want = pending_responses.pop_front();
         checked++;
         if (got.outcome !== want.outcome) flag_mismatch("outcome", want.outcome, got.outcome);
         if (got.out_key !== want.out_key) flag_mismatch("out_key", want.out_key, got.out_key);
         if (got.out_depth !== want.out_depth)
            flag_mismatch("out_depth", want.out_depth, got.out_depth);
         if (got.entry_count !== want.entry_count)
            flag_mismatch("entry_count", want.entry_count, got.entry_count);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   idle_on = 1'b0;
   bit   long_hold_request = 1'b0;

   skst_req_if req_chan ();
   skst_rsp_if rsp_chan ();

   key_set_board board = new();

   sorted_key_set_table #(
      .CAPACITY   (SET_CAPACITY),
      .DEPTH_BITS (EDEPTH_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic req_type make_req(command_type c, logic signed [KEY_W-1:0] k,
                                        logic [EDEPTH_W-1:0] d, logic [POS_W-1:0] p);
      req_type r;
      r.command = c;
      r.key = k;
      r.entry_depth = d;
      r.position = p;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      int unsigned held;
      held = board.held;
      r.entry_depth = EDEPTH_W'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 40) r.command = (held > 250) ? CMD_REMOVE : CMD_INSERT;
      else if (pick < 60) r.command = CMD_REMOVE;
      else if (pick < 75) r.command = CMD_LOOKUP;
      else if (pick < 93) r.command = CMD_READ;
      else if (pick < 96) r.command = CMD_CLEAR;
      else begin
         case ($urandom_range(0, 2))
            0:       r.command = CMD_RSVD_A;
            1:       r.command = CMD_RSVD_B;
            default: r.command = CMD_RSVD_C;
         endcase
      end
      // Favor a small key pool and held keys so hits and duplicates are common.
      pick = $urandom_range(0, 9);
      if (pick < 5) r.key = int'($urandom_range(0, 127)) - 64;
      else if (pick < 7 && held > 0) r.key = board.keys[$urandom_range(0, held - 1)];
      else if (pick == 7) begin
         case ($urandom_range(0, 5))
            0:       r.key = KEY_MIN;
            1:       r.key = KEY_MAX;
            2:       r.key = KEY_MIN + 1;
            3:       r.key = KEY_MAX - 1;
            4:       r.key = 0;
            default: r.key = -1;
         endcase
      end
      else r.key = $urandom;
      if ($urandom_range(0, 9) < 7) r.position = POS_W'($urandom_range(0, held));
      else r.position = POS_W'($urandom_range(0, SET_CAPACITY - 1));
      return r;
   endfunction

   // Offer one request from a falling edge and hold it until accepted.
   task automatic send_request(req_type r);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= r;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      board.note_request(r);
      @(negedge clock);
   endtask

   // Response side: random short stalls plus one long hold on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (reset) rsp_chan.ready <= 1'b0;
         else if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 3);
            rsp_chan.ready <= 1'b0;
         end else rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         board.check_response(rsp_chan.payload);
   end

   initial begin
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles, %0d responses outstanding", cycles,
               board.pending_responses.size());
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      logic [KEY_W-1:0] fill_key;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_on = 1'b1;

      // From the empty set: misses, edge keys, duplicates, reads and removes.
      send_request(make_req(CMD_READ, 0, 0, 0));
      send_request(make_req(CMD_LOOKUP, 0, 0, 0));
      send_request(make_req(CMD_REMOVE, 0, 0, 0));
      send_request(make_req(CMD_INSERT, KEY_MIN, 8'h00, 0));
      send_request(make_req(CMD_INSERT, KEY_MAX, 8'hFF, 10'h3FF));
      send_request(make_req(CMD_INSERT, 0, 8'h5A, 0));
      send_request(make_req(CMD_INSERT, -1, 8'hA5, 0));
      send_request(make_req(CMD_INSERT, 1, 8'h3C, 0));
      send_request(make_req(CMD_INSERT, 0, 8'hC3, 0));
      send_request(make_req(CMD_LOOKUP, KEY_MIN, 0, 0));
      send_request(make_req(CMD_LOOKUP, KEY_MAX, 0, 0));
      send_request(make_req(CMD_LOOKUP, 2, 0, 0));
      send_request(make_req(CMD_READ, 0, 0, 0));
      send_request(make_req(CMD_READ, 0, 0, 4));
      send_request(make_req(CMD_READ, 0, 0, 5));
      send_request(make_req(CMD_READ, 0, 0, 10'h3FF));
      send_request(make_req(CMD_REMOVE, -1, 0, 0));
      send_request(make_req(CMD_REMOVE, KEY_MAX, 0, 0));
      send_request(make_req(CMD_REMOVE, KEY_MIN, 0, 0));
      send_request(make_req(CMD_RSVD_A, KEY_MAX, 8'hFF, 10'h3FF));
      send_request(make_req(CMD_RSVD_B, 0, 0, 0));
      send_request(make_req(CMD_RSVD_C, KEY_MIN, 8'h55, 10'h2AA));
      send_request(make_req(CMD_CLEAR, 0, 0, 0));
      send_request(make_req(CMD_READ, 0, 0, 0));

      // Fill to capacity with ascending even keys so each insert appends.
      for (int k = 0; k < SET_CAPACITY; k++) begin
         fill_key = 32'h8000_0000 + (32'(k) << 22) + (32'($urandom_range(0, 32'h1F_FFFF)) << 1);
         send_request(make_req(CMD_INSERT, fill_key, EDEPTH_W'($urandom_range(0, 255)), 0));
      end
      send_request(make_req(CMD_INSERT, 1, 8'h11, 0));
      send_request(make_req(CMD_INSERT, board.keys[512], 8'h22, 0));
      send_request(make_req(CMD_LOOKUP, board.keys[SET_CAPACITY-1], 0, 0));
      send_request(make_req(CMD_READ, 0, 0, 10'h3FF));
      send_request(make_req(CMD_READ, 0, 0, 0));
      fill_key = board.keys[3];
      send_request(make_req(CMD_REMOVE, fill_key, 0, 0));
      send_request(make_req(CMD_INSERT, fill_key, 8'h99, 0));
      send_request(make_req(CMD_READ, 0, 0, 3));
      send_request(make_req(CMD_INSERT, 1, 8'h11, 0));
      send_request(make_req(CMD_CLEAR, 0, 0, 0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == PRESSURE_ITEM) long_hold_request = 1'b1;
         if (n == RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
         send_request(random_request());
      end
      req_chan.valid <= 1'b0;

      while (board.pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.pending_responses.size() != 0) begin
         board.errors++;
         $display("%0t: %0d responses never arrived", $time, board.pending_responses.size());
      end

      $display("Summary: %0d responses checked, outcomes ok/miss/full/range = %0d/%0d/%0d/%0d",
               board.checked, board.tally[OUT_OK], board.tally[OUT_MISS],
               board.tally[OUT_FULL], board.tally[OUT_RANGE]);
      $display("Summary: peak occupancy %0d of %0d entries, %0d clears, %0d errors",
               board.peak, SET_CAPACITY, board.clears, board.errors);
      if (board.errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
`default_nettype wire

[files.f]
design/skst_pkg.sv
design/skst_ifs.sv
design/skst_store.sv
design/skst_ctrl.sv
design/sorted_key_set_table.sv
test/testbench.sv
